### rtl/glob_name_filter_defines.svh
//------------------------------------------------------------------------------
// glob_name_filter assertion macros
// Shared property forms for the checkers of the name filter.
//------------------------------------------------------------------------------
`ifndef GLOB_NAME_FILTER_DEFINES_SVH
`define GLOB_NAME_FILTER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define GNF_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("glob_name_filter check failed in the same cycle");

// The condition must hold in the cycle after the trigger.
`define GNF_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("glob_name_filter check failed in the following cycle");

`endif

### rtl/gnf_pkg.sv
//------------------------------------------------------------------------------
// gnf_pkg
// Types and constants shared by the wildcard name filter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gnf_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_FILTER_ON = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_FILTER    = 3'd4;

    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] QMARK_CHAR = 8'h3F;

    localparam logic [1:0] TYPE_ANY  = 2'd0;
    localparam logic [1:0] TYPE_FILE = 2'd1;
    localparam logic [1:0] TYPE_DIR  = 2'd2;

    typedef struct packed {
        logic       step;
        logic       restart;
        logic [7:0] ch;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/gnf_cell.sv
//------------------------------------------------------------------------------
// gnf_cell
// One pattern position: holds its pattern byte and its active bit, passes
// star closure and character advance on to the next position.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gnf_cell
    import gnf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_init_bit,
    input  wire logic      i_enabled,
    input  wire logic      i_pat_we,
    input  wire logic [7:0] i_pat_data,
    input  wire logic      i_live_in,
    input  wire logic      i_adv_in,
    output logic           o_live,
    output logic           o_live_out,
    output logic           o_adv_out
);

    logic [7:0] r_pat;
    logic       r_act;
    logic       n_act;
    logic       w_star;
    logic       w_hit;

    assign w_star     = (r_pat == STAR_CHAR);
    assign w_hit      = (r_pat == QMARK_CHAR) || (r_pat == i_ctl.ch);
    assign o_live     = r_act | i_live_in;
    assign o_live_out = o_live & i_enabled & w_star;
    assign o_adv_out  = o_live & i_enabled & ~w_star & w_hit;
    assign n_act      = o_live_out | i_adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= 8'h00;
        end else if (i_pat_we) begin
            r_pat <= i_pat_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_act <= i_init_bit;
        end else if (i_ctl.step) begin
            r_act <= n_act;
        end
    end

endmodule

`default_nettype wire

### rtl/glob_name_filter.sv
// The filter takes one transaction per clock cycle on the input side, name
// characters and terminators alike, and returns the result of a name in the
// cycle after its terminator is accepted, held in an output register. Input
// ready is low only while that register holds a result that is not being taken.
// Star closure ripples combinationally through the row of position cells, so
// the cell chain length (PATTERN_CHARS) sets the critical path, not the rate.
//------------------------------------------------------------------------------
// glob_name_filter
// Shell-style wildcard and entry type filter over a streamed name.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glob_name_filter
    import gnf_pkg::*;
#(
    parameter int PATTERN_CHARS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [7:0]             i_ch,
    input  wire logic                   i_is_end,
    input  wire logic                   i_is_dir,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_selected,
    output logic                        o_name_matched
);

    localparam int         IDX_W   = $clog2(PATTERN_CHARS + 1);
    localparam logic [4:0] LEN_MAX = 5'(PATTERN_CHARS);

    logic [4:0] r_len;
    logic       r_filter_on;
    logic [1:0] r_type;
    logic       r_final;
    logic       r_out_valid;
    logic       r_selected;
    logic       r_name_matched;

    logic [4:0]             w_len_used;
    logic [PATTERN_CHARS:0] w_live;
    logic [PATTERN_CHARS:0] w_live_chain;
    logic [PATTERN_CHARS:0] w_adv_chain;
    logic                   w_accept;
    logic                   w_pat_ok;
    logic                   w_name_ok;
    logic                   w_type_ok;
    t_cell_ctl              w_ctl;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_len_used = (r_len > LEN_MAX) ? LEN_MAX : r_len;

    assign w_ctl.step    = w_accept & ~i_is_end;
    assign w_ctl.restart = w_accept & i_is_end;
    assign w_ctl.ch      = i_ch;

    assign w_live_chain[0] = 1'b0;
    assign w_adv_chain[0]  = 1'b0;

    for (genvar p = 0; p < PATTERN_CHARS; p++) begin : g_cell
        logic w_we;
        if (p < 8) begin : g_low
            assign w_we = i_cfg_wr_en && (i_cfg_index == REG_PATTERN_LOW);
        end else begin : g_high
            assign w_we = i_cfg_wr_en && (i_cfg_index == REG_PATTERN_HIGH);
        end

        gnf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_init_bit ((p == 0) ? 1'b1 : 1'b0),
            .i_enabled  (w_len_used > 5'(p)),
            .i_pat_we   (w_we),
            .i_pat_data (i_cfg_data[8*(p%8) +: 8]),
            .i_live_in  (w_live_chain[p]),
            .i_adv_in   (w_adv_chain[p]),
            .o_live     (w_live[p]),
            .o_live_out (w_live_chain[p+1]),
            .o_adv_out  (w_adv_chain[p+1])
        );
    end

    assign w_live[PATTERN_CHARS] = r_final | w_live_chain[PATTERN_CHARS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_ctl.restart) begin
            r_final <= 1'b0;
        end else if (w_ctl.step) begin
            r_final <= w_adv_chain[PATTERN_CHARS];
        end
    end

    assign w_pat_ok  = w_live[w_len_used[IDX_W-1:0]];
    assign w_name_ok = r_filter_on ? w_pat_ok : 1'b1;

    always_comb begin
        case (r_type)
            TYPE_FILE: w_type_ok = ~i_is_dir;
            TYPE_DIR:  w_type_ok = i_is_dir;
            TYPE_ANY:  w_type_ok = 1'b1;
            default:   w_type_ok = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= 5'd0;
            r_filter_on <= 1'b0;
            r_type      <= TYPE_ANY;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PATTERN_LENGTH: r_len       <= i_cfg_data[4:0];
                REG_NAME_FILTER_ON: r_filter_on <= i_cfg_data[0];
                REG_TYPE_FILTER:    r_type      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.restart) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.restart) begin
            r_selected     <= w_type_ok & w_name_ok;
            r_name_matched <= w_name_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_selected     = r_selected;
    assign o_name_matched = r_name_matched;

endmodule

`default_nettype wire

### rtl/gnf_checker.sv
//------------------------------------------------------------------------------
// gnf_checker
// Port-level checks of the wildcard name filter, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "glob_name_filter_defines.svh"

module gnf_checker
    import gnf_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic i_is_end,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_selected,
    input wire logic o_name_matched
);

    `GNF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_selected) && $stable(o_name_matched))
    `GNF_ASSERT_NOW(a_sel_needs_name, o_out_valid && o_selected, o_name_matched)
    `GNF_ASSERT_NEXT(a_end_gives_result, i_in_valid && o_in_ready && i_is_end, o_out_valid)
    `GNF_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)

endmodule

bind glob_name_filter gnf_checker u_gnf_checker (.*);

`default_nettype wire
